// ===== rtl/gtg_pkg.sv =====
// Shared types, constants and the arctangent table of the go-to-goal regulator.
package gtg_pkg;

    localparam int unsigned CordicIterDefault = 20;
    localparam int unsigned XW = 44;   // CORDIC x/y width
    localparam int unsigned ZW = 35;   // CORDIC angle width, Q30
    localparam int unsigned PW = 56;   // multiplier product width

    localparam logic signed [ZW-1:0] PiQ30   = 35'sd3373259426;
    localparam logic [23:0]          InvKQ24 = 24'd10188014;

    localparam logic [36:0]          QReach  = 37'd3277;
    localparam logic signed [22:0]   QTurn   = 23'sd9830;
    localparam logic signed [22:0]   QFold   = 23'sd360448;
    localparam logic signed [22:0]   QTwoPi  = 23'sd411775;
    localparam logic signed [16:0]   QSpin   = 17'sd52429;
    localparam logic [39:0]          QLinMin = 40'd6554;
    localparam logic [39:0]          QLinMax = 40'd19661;
    localparam logic [39:0]          QAngMin = 40'd9830;
    localparam logic [39:0]          QAngMax = 40'd32768;

    localparam logic [2:0] CFG_GOAL_X   = 3'd0;
    localparam logic [2:0] CFG_GOAL_Y   = 3'd1;
    localparam logic [2:0] CFG_ANG_GAIN = 3'd2;
    localparam logic [2:0] CFG_LIN_GAIN = 3'd3;

    typedef enum logic [1:0] {
        ST_NO_GOAL = 2'd0,
        ST_REACHED = 2'd1,
        ST_TURN    = 2'd2,
        ST_DRIVE   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_ITER, S_MLO, S_MHI, S_DIST, S_MLIN, S_MANG, S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cordic_ctl;

    function automatic logic [ZW-1:0] atan_entry(input logic [5:0] i);
        logic [ZW-1:0] v;
        v = '0;
        case (i)
            6'd0: v = ZW'(843314856);
            6'd1: v = ZW'(497837829);
            6'd2: v = ZW'(263043836);
            6'd3: v = ZW'(133525158);
            6'd4: v = ZW'(67021686);
            6'd5: v = ZW'(33543515);
            6'd6: v = ZW'(16775850);
            6'd7: v = ZW'(8388437);
            6'd8: v = ZW'(4194282);
            6'd9: v = ZW'(2097149);
            default: begin
                if (i <= 6'd30) begin
                    v = (ZW'(1) << (6'd30 - i)) - ZW'(1);
                end
            end
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/gtg_cordic.sv =====
// Iterative vectoring CORDIC: one shift-add rotation per cycle while step is asserted.
module gtg_cordic #(
    parameter int unsigned N = gtg_pkg::CordicIterDefault
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gtg_pkg::t_cordic_ctl             i_ctl,
    input  logic signed [gtg_pkg::XW-1:0]    i_x0,
    input  logic signed [gtg_pkg::XW-1:0]    i_y0,
    input  logic signed [gtg_pkg::ZW-1:0]    i_z0,
    output logic signed [gtg_pkg::XW-1:0]    o_x,
    output logic signed [gtg_pkg::ZW-1:0]    o_z,
    output logic                             o_done
);
    import gtg_pkg::*;

    localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;

    logic [IW-1:0]         r_i;
    logic signed [XW-1:0]  r_x, r_y;
    logic signed [ZW-1:0]  r_z;
    logic signed [XW-1:0]  w_dx, w_dy;
    logic [ZW-1:0]         w_at;

    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_at = atan_entry(6'(r_i));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
        end else if (i_ctl.load) begin
            r_i <= '0;
        end else if (i_ctl.step && !o_done) begin
            r_i <= r_i + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_x0;
            r_y <= i_y0;
            r_z <= i_z0;
        end else if (i_ctl.step) begin
            if (!r_y[XW-1]) begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + $signed(w_at);
            end else begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - $signed(w_at);
            end
        end
    end

    assign o_done = (r_i == IW'(N - 1));
    assign o_x    = r_x;
    assign o_z    = r_z;

endmodule

// ===== rtl/gtg_mul.sv =====
// Shared registered multiplier, 32 by 24 bits unsigned.
module gtg_mul (
    input  logic                    i_clk,
    input  logic [31:0]             i_a,
    input  logic [23:0]             i_b,
    output logic [gtg_pkg::PW-1:0]  o_p
);
    import gtg_pkg::*;

    logic [PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PW'(i_a) * PW'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== rtl/go_to_goal_position_regulator.sv =====
// Top level of the go-to-goal regulator: sequencer, registers and output stage.
//
//  channel  | handshake                  | payload
//  pose in  | i_in_valid / o_in_stall    | i_pose_x, i_pose_y, i_pose_yaw
//  command  | o_out_valid / i_out_stall  | o_status, o_linear_command, o_angular_command
//  config   | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A result follows its pose transfer through the CORDIC loop and four passes through the
// one multiplier; both are skipped without a goal. No pose is taken while one is at work.
// Reset is synchronous, active low; goal, gains and goal state return to defaults.
// A result held under i_out_stall holds the sequencer in its last step.
module go_to_goal_position_regulator #(
    parameter int unsigned CORDIC_ITERATIONS = gtg_pkg::CordicIterDefault
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic signed [31:0]     i_pose_x,
    input  logic signed [31:0]     i_pose_y,
    input  logic signed [18:0]     i_pose_yaw,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic [14:0]            o_linear_command,
    output logic signed [16:0]     o_angular_command,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    import gtg_pkg::*;

    t_state r_state, n_state;

    logic signed [31:0] r_goal_x, r_goal_y;
    logic [23:0]        r_ang_gain, r_lin_gain;
    logic               r_goal_active;

    logic signed [31:0] r_px, r_py;
    logic signed [18:0] r_yaw;
    logic               r_skip, r_reach;
    logic [PW-1:0]      r_acc;
    logic [31:0]        r_dist;
    logic signed [22:0] r_err;
    logic [21:0]        r_abs;
    logic [39:0]        r_linp;

    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [14:0]        r_lin;
    logic signed [16:0] r_ang;

    t_cordic_ctl          w_ctl;
    logic signed [32:0]   w_ex, w_ey;
    logic signed [XW-1:0] w_x0, w_y0, w_cx;
    logic signed [ZW-1:0] w_z0, w_cz, w_zr;
    logic                 w_cdone;
    logic [31:0]          w_ma;
    logic [23:0]          w_mb;
    logic [PW-1:0]        w_p;
    logic [63:0]          w_sum;
    logic [39:0]          w_dist;
    logic signed [20:0]   w_bear;
    logic signed [22:0]   w_err0, w_err;
    logic                 w_out_free, w_fire;
    logic [1:0]           w_status;
    logic [39:0]          w_lin, w_mag;
    logic signed [16:0]   w_ang;

    // CORDIC start vector
    assign w_ex = 33'(r_goal_x) - 33'(r_px);
    assign w_ey = 33'(r_goal_y) - 33'(r_py);

    always_comb begin
        w_x0 = {{(XW-41){w_ex[32]}}, w_ex, 8'b0};
        w_y0 = {{(XW-41){w_ey[32]}}, w_ey, 8'b0};
        w_z0 = '0;
        if (w_ex[32]) begin
            w_z0 = w_ey[32] ? -PiQ30 : PiQ30;
            w_x0 = -w_x0;
            w_y0 = -w_y0;
        end
    end

    assign w_ctl.load = (r_state == S_LOAD);
    assign w_ctl.step = (r_state == S_ITER);

    gtg_cordic #(.N(CORDIC_ITERATIONS)) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_x0   (w_x0),
        .i_y0   (w_y0),
        .i_z0   (w_z0),
        .o_x    (w_cx),
        .o_z    (w_cz),
        .o_done (w_cdone)
    );

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_MLO: begin
                w_ma = 32'(w_cx[25:8]);
                w_mb = InvKQ24;
            end
            S_MHI: begin
                w_ma = 32'(w_cx[43:26]);
                w_mb = InvKQ24;
            end
            S_MLIN: begin
                w_ma = r_dist;
                w_mb = r_lin_gain;
            end
            S_MANG: begin
                w_ma = 32'(r_abs);
                w_mb = r_ang_gain;
            end
            // product held while the result waits
            S_FIN: begin
                w_ma = 32'(r_abs);
                w_mb = r_ang_gain;
            end
            default: ;
        endcase
    end

    gtg_mul u_mul (
        .i_clk(i_clk),
        .i_a  (w_ma),
        .i_b  (w_mb),
        .o_p  (w_p)
    );

    // distance and folded heading error
    assign w_sum  = (64'(w_p) << 18) + 64'(r_acc);
    assign w_dist = w_sum[63:24];
    assign w_zr   = w_cz + ZW'(8192);
    assign w_bear = w_zr[34:14];
    assign w_err0 = 23'(w_bear) - 23'(r_yaw);

    always_comb begin
        w_err = w_err0;
        if (w_err0 < -QFold) begin
            w_err = w_err0 + QTwoPi;
        end else if (w_err0 > QFold) begin
            w_err = w_err0 - QTwoPi;
        end
    end

    // final commands
    always_comb begin
        w_lin = r_linp;
        if (w_lin > QLinMax) begin
            w_lin = QLinMax;
        end else if (w_lin != '0 && w_lin < QLinMin) begin
            w_lin = QLinMin;
        end
        w_mag = w_p[55:16];
        if (w_mag != '0) begin
            if (w_mag > QAngMax) begin
                w_mag = QAngMax;
            end else if (w_mag < QAngMin) begin
                w_mag = QAngMin;
            end
        end
        w_ang    = r_err[22] ? -$signed(17'(w_mag)) : $signed(17'(w_mag));
        w_status = ST_DRIVE;
        if (r_skip) begin
            w_status = ST_NO_GOAL;
            w_lin    = '0;
            w_ang    = '0;
        end else if (r_reach) begin
            w_status = ST_REACHED;
            w_lin    = '0;
            w_ang    = '0;
        end else if (r_err > QTurn || r_err < -QTurn) begin
            w_status = ST_TURN;
            w_lin    = '0;
            w_ang    = r_err[22] ? -QSpin : QSpin;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = (r_state == S_FIN) && w_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_LOAD;
            S_LOAD: n_state = r_goal_active ? S_ITER : S_FIN;
            S_ITER: if (w_cdone) n_state = S_MLO;
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_DIST;
            S_DIST: n_state = S_MLIN;
            S_MLIN: n_state = S_MANG;
            S_MANG: n_state = S_FIN;
            S_FIN:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and goal state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x      <= '0;
            r_goal_y      <= '0;
            r_ang_gain    <= 24'd98304;
            r_lin_gain    <= 24'd32768;
            r_goal_active <= 1'b0;
        end else begin
            if (w_fire && !r_skip && r_reach) begin
                r_goal_active <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GOAL_X: begin
                        r_goal_x      <= i_cfg_data;
                        r_goal_active <= 1'b1;
                    end
                    CFG_GOAL_Y: begin
                        r_goal_y      <= i_cfg_data;
                        r_goal_active <= 1'b1;
                    end
                    CFG_ANG_GAIN: r_ang_gain <= i_cfg_data[23:0];
                    CFG_LIN_GAIN: r_lin_gain <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_px  <= i_pose_x;
            r_py  <= i_pose_y;
            r_yaw <= i_pose_yaw;
        end
        if (r_state == S_LOAD) begin
            r_skip <= !r_goal_active;
        end
        if (r_state == S_MHI) begin
            r_acc <= w_p;
        end
        if (r_state == S_DIST) begin
            r_reach <= (37'(w_dist) < QReach) && (w_dist[39:37] == '0);
            r_dist  <= (w_dist[39:32] != '0) ? '1 : w_dist[31:0];
            r_err   <= w_err;
            r_abs   <= w_err[22] ? 22'(-w_err) : 22'(w_err);
        end
        if (r_state == S_MANG) begin
            r_linp <= w_p[55:16];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= w_status;
            r_lin    <= w_lin[14:0];
            r_ang    <= w_ang;
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_linear_command  = r_lin;
    assign o_angular_command = r_ang;

    a_fire_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("result appeared outside the final step");

    a_no_goal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_NO_GOAL || o_status == ST_REACHED))
            |-> (o_linear_command == '0 && o_angular_command == '0))
        else $error("commands not zero without a goal");

    a_drive_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_DRIVE) |-> (o_linear_command <= 15'd19661))
        else $error("linear command beyond clamp");

    a_reach_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid) && o_status == ST_REACHED)
            |-> (!r_goal_active || $past(i_cfg_we)))
        else $error("goal still armed after reach");

endmodule

// ===== tb/sv/tb_go_to_goal_position_regulator.sv =====
// Self-checking bench for the go-to-goal regulator: pose transfers against a bit-true predictor.
module tb_go_to_goal_position_regulator;
    timeunit 1ns;
    timeprecision 1ps;
    import gtg_pkg::*;

    localparam int unsigned NumRandom = 500;
    localparam int unsigned IdleLimit = 20000;
    localparam int unsigned CordicSteps = CordicIterDefault;
    localparam logic [2:0]  CfgUnused = 3'd5;

    typedef struct packed {
        logic [1:0]         status;
        logic [14:0]        lin;
        logic signed [16:0] ang;
    } t_command;

    class command_board;
        logic signed [31:0] goal_x, goal_y;
        logic [23:0]        ang_gain, lin_gain;
        bit                 armed;
        t_command           pending[$];
        int                 errors;
        int                 checked;
        int                 status_seen[4];

        function new();
            goal_x = '0; goal_y = '0;
            ang_gain = 24'd98304; lin_gain = 24'd32768;
            armed = 0; errors = 0; checked = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_GOAL_X: begin goal_x = val; armed = 1; end
                CFG_GOAL_Y: begin goal_y = val; armed = 1; end
                CFG_ANG_GAIN: ang_gain = val[23:0];
                CFG_LIN_GAIN: lin_gain = val[23:0];
                default: ;
            endcase
        endfunction

        function longint arctan(int i);
            longint head[10];
            head = '{843314856, 497837829, 263043836, 133525158, 67021686,
                     33543515, 16775850, 8388437, 4194282, 2097149};
            if (i < 10) return head[i];
            if (i <= 30) return (64'sd1 <<< (30 - i)) - 1;
            return 0;
        endfunction

        function void note_pose(logic signed [31:0] px, logic signed [31:0] py,
                                logic signed [18:0] yaw);
            t_command c;
            longint x, y, z, dx, dy, range_q, bearing, err, lin, mag, ang;
            c = '0;
            if (!armed) begin
                pending.push_back(c);
                return;
            end
            x = (longint'(goal_x) - longint'(px)) * 256;
            y = (longint'(goal_y) - longint'(py)) * 256;
            z = 0;
            if (x < 0) begin
                z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
                x = -x; y = -y;
            end
            for (int i = 0; i < CordicSteps; i++) begin
                dx = y >>> i; dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += arctan(i);
                end else begin
                    x -= dx; y += dy; z -= arctan(i);
                end
            end
            range_q = ((x >>> 8) * 64'sd10188014) >>> 24;
            bearing = (z + 8192) >>> 14;
            err = bearing - longint'(yaw);
            if (err < -360448) err += 411775;
            if (err > 360448) err -= 411775;
            if (range_q < 3277) begin
                armed = 0;
                c.status = ST_REACHED;
            end else if (err > 9830 || err < -9830) begin
                c.status = ST_TURN;
                c.ang = (err > 0) ? 17'sd52429 : -17'sd52429;
            end else begin
                lin = (range_q * longint'(lin_gain)) >>> 16;
                if (lin > 19661) lin = 19661;
                if (lin > 0 && lin < 6554) lin = 6554;
                mag = ((err < 0 ? -err : err) * longint'(ang_gain)) >>> 16;
                if (mag != 0) begin
                    if (mag > 32768) mag = 32768;
                    if (mag < 9830) mag = 9830;
                end
                ang = (err < 0) ? -mag : mag;
                c.status = ST_DRIVE;
                c.lin = lin[14:0];
                c.ang = ang[16:0];
            end
            pending.push_back(c);
        endfunction

        function void check_command(t_command got);
            t_command want;
            if (pending.size() == 0) begin
                $error("unexpected command transfer status=%0d", got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.status !== want.status) begin
                $error("status exp %0d got %0d", want.status, got.status); errors++;
            end
            if (got.lin !== want.lin) begin
                $error("linear_command exp %0d got %0d", want.lin, got.lin); errors++;
            end
            if (got.ang !== want.ang) begin
                $error("angular_command exp %0d got %0d", want.ang, got.ang); errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0, i_rst_n = 0;
    logic               i_in_valid = 0, i_out_stall = 0, i_cfg_we = 0;
    logic signed [31:0] i_pose_x = '0, i_pose_y = '0;
    logic signed [18:0] i_pose_yaw = '0;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               o_in_stall, o_out_valid;
    logic [1:0]         o_status;
    logic [14:0]        o_linear_command;
    logic signed [16:0] o_angular_command;

    command_board board = new();
    int  idle_cycles = 0;
    bit  out_busy = 1;

    go_to_goal_position_regulator u_top (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_command({o_status, o_linear_command, o_angular_command});
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("watchdog expired: no transfer for %0d cycles", IdleLimit);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall pattern: bursts of stall, some stretches with none
    initial begin
        int n;
        forever begin
            n = out_busy ? gap_len() : 0;
            repeat (n) begin
                @(posedge i_clk);
                i_out_stall <= 1;
            end
            @(posedge i_clk);
            i_out_stall <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        board.write_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_pose(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [18:0] yaw, bit with_gaps);
        if (with_gaps) repeat (gap_len()) @(posedge i_clk);
        i_in_valid <= 1; i_pose_x <= px; i_pose_y <= py; i_pose_yaw <= yaw;
        do @(posedge i_clk); while (o_in_stall);
        board.note_pose(px, py, yaw);
        i_in_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic set_goal(logic signed [31:0] gx, logic signed [31:0] gy);
        drain();
        write_reg(CFG_GOAL_X, gx);
        write_reg(CFG_GOAL_Y, gy);
    endtask

    function automatic logic signed [31:0] near(logic signed [31:0] c, int span);
        return c + $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    initial begin
        logic signed [31:0] gx, gy;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        send_pose(32'sh0, 32'sh0, 19'sh0, 0);
        drain();
        write_reg(CFG_LIN_GAIN, 32'd32768);
        write_reg(CFG_ANG_GAIN, 32'd98304);
        write_reg(CfgUnused, 32'hFFFF_FFFF);
        send_pose(32'sh0, 32'sh0, 19'sh0, 0);
        set_goal(32'sd65536, 32'sd0);
        send_pose(32'sd0, 32'sd0, 19'sd0, 0);
        send_pose(32'sd0, 32'sd0, 19'sd205887, 0);
        send_pose(32'sd0, 32'sd0, -19'sd205887, 0);
        send_pose(32'sd0, 32'sd0, 19'sh3FFFF, 0);
        send_pose(32'sd0, 32'sd0, 19'sh40000, 0);
        send_pose(32'sd131072, 32'sd100, 19'sd0, 0);
        send_pose(32'sd131072, -32'sd100, 19'sd0, 0);
        send_pose(32'sd65536, 32'sd2000, 19'sd0, 0);
        send_pose(32'sd0, 32'sd0, 19'sd0, 0);
        set_goal(32'h7FFF_FFFF, 32'h8000_0000);
        send_pose(32'h8000_0000, 32'h7FFF_FFFF, 19'sd0, 0);
        send_pose(32'h7FFF_FFFF, 32'h8000_0000, 19'sd0, 0);
        drain();
        write_reg(CFG_LIN_GAIN, 32'd0);
        write_reg(CFG_ANG_GAIN, 32'd0);
        set_goal(32'sd655360, 32'sd0);
        send_pose(32'sd0, 32'sd0, 19'sd0, 0);
        send_pose(32'sd0, 32'sd0, 19'sd300, 0);
        drain();
        write_reg(CFG_LIN_GAIN, 32'hFFFF_FFFF);
        write_reg(CFG_ANG_GAIN, 32'h00FF_FFFF);
        send_pose(32'sd0, 32'sd0, 19'sd300, 0);
        send_pose(32'sd0, 32'sd0, -19'sd300, 0);
        send_pose(32'sd655360, 32'sd0, 19'sd0, 0);

        for (int i = 0; i < NumRandom; i++) begin
            if (i % 25 == 0) begin
                drain();
                write_reg(CFG_LIN_GAIN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 131072));
                write_reg(CFG_ANG_GAIN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 262144));
                gx = $urandom_range(0, 7) == 0 ? $urandom : near(0, 1 << 20);
                gy = $urandom_range(0, 7) == 0 ? $urandom : near(0, 1 << 20);
                set_goal(gx, gy);
            end
            case ($urandom_range(0, 9))
                0: send_pose(32'($urandom), 32'($urandom), 19'($urandom), 1);
                1: send_pose(near(board.goal_x, 4000), near(board.goal_y, 4000),
                             19'($urandom), 1);
                default: send_pose(near(board.goal_x, 1 << 18), near(board.goal_y, 1 << 18),
                                   19'($urandom_range(0, 411774) - 205887), 1);
            endcase
        end
        out_busy = 0;
        drain();
        $display("checked %0d commands: %0d no goal, %0d reached, %0d turn, %0d drive",
                 board.checked, board.status_seen[0], board.status_seen[1],
                 board.status_seen[2], board.status_seen[3]);
        $display("gains and goals rewritten across the run, extremes included");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
